// ===== src/emts_pkg.sv =====
// Package for the trainable scalar perceptron: sizes, payload structs,
// sequencer states and the fixed-point helpers, all saturating but lr_post.
// No dependencies.
package emts_pkg;

  localparam int HIDDEN_NODES = 8;
  localparam int FRAC_BITS    = 16;
  localparam int LR_SHIFT     = 16;
  localparam int NODE_W       = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;

  localparam logic [1:0] MODE_FORWARD  = 2'd0;
  localparam logic [1:0] MODE_BACKPROP = 2'd1;
  localparam logic [1:0] MODE_LOAD     = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [4:0]         param_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] w1;
    logic signed [31:0] b1;
    logic signed [31:0] w2;
    logic signed [31:0] h;
  } node_t;

  typedef struct packed {
    logic               w1_en;
    logic               b1_en;
    logic               w2_en;
    logic signed [31:0] value;
  } load_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BIAS,
    ST_BWD,
    ST_DONE
  } state_e;

  function automatic sat_t clip32(input logic signed [65:0] v);
    sat_t r;
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh7FFF_FFFF;
    lo = $signed({{34{1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      r.sat = 1'b1;
      r.val = $signed(32'h8000_0000);
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t mul_post(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return clip32(66'(s));
  endfunction

  function automatic logic signed [31:0] lr_post(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> LR_SHIFT;
    return s[31:0];
  endfunction

  function automatic sat_t add_sat(input logic signed [31:0] a, input logic signed [31:0] b,
                                   input logic sub);
    logic signed [65:0] s;
    s = sub ? (66'(a) - 66'(b)) : (66'(a) + 66'(b));
    return clip32(s);
  endfunction

endpackage

// ===== src/edge_mlp_train_step_unit.sv =====
// Top level of the trainable scalar perceptron with one ReLU hidden layer.
// Depends on emts_pkg and emts_cell.
//
// Items arrive on the in channel (in_valid_i, in_ready_o, in_data_i). A load
// item writes one parameter in the cycle of its transfer and gives no result;
// mode 3 is dropped. Forward and backprop items give one result on the out
// channel (out_valid_o, out_ready_i, out_data_o). The learning rate is written
// through the cfg channel, which is always ready; write it only while idle.
// The hidden nodes sit in a ring of cells that rotates by one node each time
// the shared multiplier has finished that node, so every forward and backprop
// item walks all nodes; backprop first updates the output bias. After the last
// node the sequencer waits in its done state until the output register is free
// and then registers the result into it. Only one item is in work at a time; a
// new item is accepted while a result waits in the output register, but its
// own result waits until that register is free.
// Reset clears the saved input and the activations and sets the learning rate
// to 655; weights and biases must be loaded before use.
module edge_mlp_train_step_unit import emts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [15:0] lr_q;
  logic signed [31:0] x_q, x_d, d_q, d_d, b2_q, b2_d, acc_q, acc_d;
  logic signed [31:0] a_q, a_d, dh_q, dh_d, t_q, t_d, u_q, u_d, nw2_q, nw2_d, nb1_q, nb1_d;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_q;
  logic sat_q, sat_d;
  logic shift;
  logic last_node;
  logic accept;
  node_t head, wb;
  node_t cells [HIDDEN_NODES];
  out_item_t out_q;
  logic out_valid_q;
  logic signed [31:0] lr32;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign head = cells[0];
  assign last_node = (node_q == NODE_W'(HIDDEN_NODES - 1));
  assign lr32 = $signed({16'b0, lr_q});

  for (genvar j = 0; j < HIDDEN_NODES; j++) begin : g_cell
    load_t ld;
    node_t nxt;
    always_comb begin
      ld.value = in_data_i.value;
      ld.w1_en = accept && (in_data_i.mode == MODE_LOAD)
                 && (32'(in_data_i.param_index) == 32'(j));
      ld.b1_en = accept && (in_data_i.mode == MODE_LOAD)
                 && (32'(in_data_i.param_index) == 32'(HIDDEN_NODES + j));
      ld.w2_en = accept && (in_data_i.mode == MODE_LOAD)
                 && (32'(in_data_i.param_index) == 32'(2 * HIDDEN_NODES + j));
    end
    if (j == HIDDEN_NODES - 1) begin : g_tail
      assign nxt = wb;
    end else begin : g_mid
      assign nxt = cells[j + 1];
    end
    emts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .next_i (nxt),
      .load_i (ld),
      .node_o (cells[j])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    node_d  = node_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        node_d = '0;
        if (accept && in_data_i.mode == MODE_FORWARD) begin
          state_d = ST_FWD;
        end else if (accept && in_data_i.mode == MODE_BACKPROP) begin
          state_d = ST_BIAS;
        end
      end
      ST_FWD: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          step_d = '0;
          node_d = node_q + NODE_W'(1);
          if (last_node) state_d = ST_DONE;
        end
      end
      ST_BIAS: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd1) begin
          step_d  = '0;
          state_d = ST_BWD;
        end
      end
      ST_BWD: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          node_d = node_q + NODE_W'(1);
          if (last_node) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sat_t r;
    sat_t s;
    x_d = x_q;
    d_d = d_q;
    b2_d = b2_q;
    acc_d = acc_q;
    a_d = a_q;
    dh_d = dh_q;
    t_d = t_q;
    u_d = u_q;
    nw2_d = nw2_q;
    nb1_d = nb1_q;
    sat_d = sat_q;
    opa = d_q;
    opb = head.w2;
    shift = 1'b0;
    wb = head;
    r = mul_post(prod_q);
    s = '0;
    unique case (state_q)
      ST_IDLE: begin
        sat_d = 1'b0;
        if (accept && in_data_i.mode == MODE_FORWARD) begin
          x_d   = in_data_i.value;
          acc_d = b2_q;
        end else if (accept && in_data_i.mode == MODE_BACKPROP) begin
          d_d   = in_data_i.value;
          acc_d = '0;
        end else if (accept && in_data_i.mode == MODE_LOAD
                     && 32'(in_data_i.param_index) == 32'(3 * HIDDEN_NODES)) begin
          b2_d = in_data_i.value;
        end
      end
      ST_FWD: begin
        unique case (step_q[1:0])
          2'd0: begin
            opa = head.w1;
            opb = x_q;
          end
          2'd1: begin
            s = add_sat(head.b1, r.val, 1'b0);
            a_d = s.val[31] ? '0 : s.val;
            sat_d = sat_q | r.sat | s.sat;
          end
          2'd2: begin
            opa = head.w2;
            opb = a_q;
          end
          default: begin
            s = add_sat(acc_q, r.val, 1'b0);
            acc_d = s.val;
            sat_d = sat_q | r.sat | s.sat;
            wb.h = a_q;
            shift = 1'b1;
          end
        endcase
      end
      ST_BIAS: begin
        opa = lr32;
        opb = d_q;
        if (step_q[0]) begin
          s = add_sat(b2_q, lr_post(prod_q), 1'b1);
          b2_d = s.val;
          sat_d = sat_q | s.sat;
        end
      end
      ST_BWD: begin
        unique case (step_q)
          3'd0: begin
            opa = d_q;
            opb = head.w2;
          end
          3'd1: begin
            dh_d = (head.h != '0) ? r.val : '0;
            sat_d = sat_q | ((head.h != '0) & r.sat);
            opa = d_q;
            opb = head.h;
          end
          3'd2: begin
            t_d = r.val;
            sat_d = sat_q | r.sat;
            opa = dh_q;
            opb = head.w1;
          end
          3'd3: begin
            s = add_sat(acc_q, r.val, 1'b0);
            acc_d = s.val;
            sat_d = sat_q | r.sat | s.sat;
            opa = dh_q;
            opb = x_q;
          end
          3'd4: begin
            u_d = r.val;
            sat_d = sat_q | r.sat;
            opa = lr32;
            opb = t_q;
          end
          3'd5: begin
            s = add_sat(head.w2, lr_post(prod_q), 1'b1);
            nw2_d = s.val;
            sat_d = sat_q | s.sat;
            opa = lr32;
            opb = dh_q;
          end
          3'd6: begin
            s = add_sat(head.b1, lr_post(prod_q), 1'b1);
            nb1_d = s.val;
            sat_d = sat_q | s.sat;
            opa = lr32;
            opb = u_q;
          end
          default: begin
            s = add_sat(head.w1, lr_post(prod_q), 1'b1);
            sat_d = sat_q | s.sat;
            wb.w1 = s.val;
            wb.b1 = nb1_q;
            wb.w2 = nw2_q;
            shift = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(opa) * 64'(opb);
    d_q    <= d_d;
    b2_q   <= b2_d;
    acc_q  <= acc_d;
    a_q    <= a_d;
    dh_q   <= dh_d;
    t_q    <= t_d;
    u_q    <= u_d;
    nw2_q  <= nw2_d;
    nb1_q  <= nb1_d;
    sat_q  <= sat_d;
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.result_value <= acc_q;
      out_q.saturated    <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      node_q      <= '0;
      x_q         <= '0;
      lr_q        <= 16'd655;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      node_q  <= node_d;
      x_q     <= x_d;
      if (cfg_valid_i && cfg_ready_o) lr_q <= cfg_data_i;
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/emts_cell.sv =====
// One hidden node of the perceptron: its two weights, bias and activation.
// Shifts its contents toward the head of the ring or takes a parameter load.
// Depends on emts_pkg.
module emts_cell import emts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  node_t next_i,
  input  load_t load_i,
  output node_t node_o
);

  logic signed [31:0] w1_q;
  logic signed [31:0] b1_q;
  logic signed [31:0] w2_q;
  logic signed [31:0] h_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      w1_q <= next_i.w1;
      b1_q <= next_i.b1;
      w2_q <= next_i.w2;
    end else begin
      if (load_i.w1_en) w1_q <= load_i.value;
      if (load_i.b1_en) b1_q <= load_i.value;
      if (load_i.w2_en) w2_q <= load_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else if (shift_i) begin
      h_q <= next_i.h;
    end
  end

  assign node_o = '{w1: w1_q, b1: b1_q, w2: w2_q, h: h_q};

endmodule
